FILE: rtl/core/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 4;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LEN   = 2'd0,
    CFG_PAT_BYTES = 2'd1,
    CFG_REP_LEN   = 2'd2,
    CFG_REP_BYTES = 2'd3
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take the input word into the window
    logic gen_win;    // emit the oldest window byte and shift
    logic gen_rep;    // emit the current replacement byte
    logic clr_count;  // drop the window after a full match
    logic clr_idx;    // restart the replacement index
    logic tail;       // close the step: push held byte or end marker
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mismatch;   // window is not empty and not a pattern prefix
    logic full_match; // window holds as many bytes as the pattern
    logic fin;        // current word was the last of the text
    logic cnt_zero;   // window is empty
    logic rep_zero;   // replacement is empty
    logic rep_last;   // replacement index is on its last byte
    logic held_v;     // a byte waits in the hold register
    logic slot_ok;    // output register can take a word this cycle
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfr_in_if.sv
// Input channel: one text byte with its last-byte flag.
`default_nettype none

interface sfr_in_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::BYTE_W-1:0]   text_byte;
  logic                         final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sfr_out_if.sv
// Result channel: one rewritten byte with its framing flags.
`default_nettype none

interface sfr_out_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::BYTE_W-1:0]   out_byte;
  logic                         byte_present;
  logic                         run_last;
  logic                         text_end;

  modport source (output valid, out_byte, byte_present, run_last, text_end, input ready);
  modport sink   (input valid, out_byte, byte_present, run_last, text_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sfr_ctrl.sv
// Controller state machine for the stream find-and-replace block.
`default_nettype none

module sfr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sfr_pkg::sts_t sts,
  output sfr_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_REPL  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_TAIL  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   can_gen;

  assign in_ready = (state_r == S_IDLE);
  // A new byte may be produced unless it would displace a held byte into a full output.
  assign can_gen  = !sts.held_v || sts.slot_ok;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mismatch) begin
          if (can_gen) begin
            cmd.gen_win = 1'b1;
          end
        end else if (sts.full_match) begin
          cmd.clr_count = 1'b1;
          cmd.clr_idx   = 1'b1;
          state_nxt     = sts.rep_zero ? S_TAIL : S_REPL;
        end else if (sts.fin) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_REPL: begin
        if (can_gen) begin
          cmd.gen_rep = 1'b1;
          if (sts.rep_last) begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_FLUSH: begin
        if (sts.cnt_zero) begin
          state_nxt = S_TAIL;
        end else if (can_gen) begin
          cmd.gen_win = 1'b1;
        end
      end
      S_TAIL: begin
        if (sts.held_v || sts.fin) begin
          if (sts.slot_ok) begin
            cmd.tail  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sfr_dpath.sv
// Datapath: configuration registers, pending window, hold and output registers.
`default_nettype none

module sfr_dpath #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sfr_pkg::cmd_t                  cmd,
  output sfr_pkg::sts_t                       sts,
  input  wire logic [sfr_pkg::BYTE_W-1:0]     in_text_byte,
  input  wire logic                           in_final_byte,
  input  wire logic                           cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [sfr_pkg::BYTE_W-1:0]          out_byte,
  output logic                                out_byte_present,
  output logic                                out_run_last,
  output logic                                out_text_end
);

  localparam int CW  = $clog2(PATTERN_MAX + 1);
  localparam int RW  = $clog2(REPLACE_MAX + 1);
  localparam int RXW = RW + 3;

  logic [sfr_pkg::LEN_W-1:0]      pat_len_r;
  logic [sfr_pkg::CFG_DATA_W-1:0] pat_bytes_r;
  logic [sfr_pkg::LEN_W-1:0]      rep_len_r;
  logic [sfr_pkg::CFG_DATA_W-1:0] rep_bytes_r;

  logic [sfr_pkg::BYTE_W-1:0] win_r   [PATTERN_MAX];
  logic [sfr_pkg::BYTE_W-1:0] win_nxt [PATTERN_MAX];
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic [CW-1:0]              wpos;
  logic                       fin_r;
  logic [RW-1:0]              rep_idx_r;
  logic [sfr_pkg::BYTE_W-1:0] held_r;
  logic                       held_v_r;

  logic                       out_v_r;
  logic [sfr_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_pres_r;
  logic                       out_last_r;
  logic                       out_end_r;

  logic [CW-1:0]              plen;
  logic [RW-1:0]              rlen;
  logic [PATTERN_MAX-1:0]     diff;
  logic [RXW-1:0]             rep_x;
  logic [sfr_pkg::BYTE_W-1:0] rep_byte;
  logic [sfr_pkg::BYTE_W-1:0] gen_byte;
  logic                       gen;
  logic                       push;

  // Effective lengths: empty pattern counts as one byte, both saturate at their maximum.
  always_comb begin
    if (pat_len_r == '0) begin
      plen = CW'(1);
    end else if (32'(pat_len_r) > PATTERN_MAX) begin
      plen = CW'(PATTERN_MAX);
    end else begin
      plen = CW'(pat_len_r);
    end
    if (32'(rep_len_r) > REPLACE_MAX) begin
      rlen = RW'(REPLACE_MAX);
    end else begin
      rlen = RW'(rep_len_r);
    end
  end

  // Per-entry compare against the pattern; bytes past the register read as zero.
  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cmp
    logic [sfr_pkg::BYTE_W-1:0] pb;
    if (g < 8) begin : g_in
      assign pb = pat_bytes_r[8*g +: 8];
    end else begin : g_out
      assign pb = '0;
    end
    assign diff[g] = (32'(count_r) > g) && (win_r[g] != pb);
  end

  assign rep_x    = RXW'(rep_idx_r);
  assign rep_byte = (rep_x < RXW'(8)) ? rep_bytes_r[{rep_x[2:0], 3'b000} +: 8] : '0;
  assign gen_byte = cmd.gen_rep ? rep_byte : win_r[0];
  assign gen      = cmd.gen_win || cmd.gen_rep;
  assign push     = (gen && held_v_r) || cmd.tail;

  assign wpos = (32'(count_r) >= PATTERN_MAX) ? CW'(PATTERN_MAX - 1) : count_r;

  always_comb begin
    win_nxt   = win_r;
    count_nxt = count_r;
    if (cmd.load) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (32'(wpos) == i) begin
          win_nxt[i] = in_text_byte;
        end
      end
      count_nxt = wpos + CW'(1);
    end else if (cmd.gen_win) begin
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      count_nxt = count_r - CW'(1);
    end else if (cmd.clr_count) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (cmd.load) begin
      fin_r <= in_final_byte;
    end
    if (gen) begin
      held_r <= gen_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rep_idx_r <= '0;
      held_v_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clr_idx) begin
        rep_idx_r <= '0;
      end else if (cmd.gen_rep) begin
        rep_idx_r <= rep_idx_r + RW'(1);
      end
      if (gen) begin
        held_v_r <= 1'b1;
      end else if (cmd.tail) begin
        held_v_r <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= sfr_pkg::LEN_W'(1);
      pat_bytes_r <= '0;
      rep_len_r   <= '0;
      rep_bytes_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::CFG_PAT_LEN:   pat_len_r   <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::CFG_PAT_BYTES: pat_bytes_r <= cfg_data;
        sfr_pkg::CFG_REP_LEN:   rep_len_r   <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::CFG_REP_BYTES: rep_bytes_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register: a held byte moves out once the next byte or the step end is known.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (cmd.tail && !held_v_r) begin
        out_byte_r <= '0;
        out_pres_r <= 1'b0;
        out_last_r <= 1'b1;
        out_end_r  <= 1'b1;
      end else begin
        out_byte_r <= held_r;
        out_pres_r <= 1'b1;
        out_last_r <= cmd.tail;
        out_end_r  <= cmd.tail && fin_r;
      end
    end
  end

  assign sts.mismatch   = (count_r != '0) && ((count_r > plen) || (|diff));
  assign sts.full_match = (count_r == plen);
  assign sts.fin        = fin_r;
  assign sts.cnt_zero   = (count_r == '0);
  assign sts.rep_zero   = (rlen == '0);
  assign sts.rep_last   = ((32'(rep_idx_r) + 1) == 32'(rlen));
  assign sts.held_v     = held_v_r;
  assign sts.slot_ok    = !out_v_r || out_ready;

  assign out_valid        = out_v_r;
  assign out_byte         = out_byte_r;
  assign out_byte_present = out_pres_r;
  assign out_run_last     = out_last_r;
  assign out_text_end     = out_end_r;

endmodule

`default_nettype wire

FILE: rtl/core/stream_find_replace.sv
// Top level of the streaming find-and-replace block.
// Flow: a text byte is accepted only while the controller is idle; the window check,
//   replacement and, for a byte that ends the text, a flush follow, and the next byte
//   is not taken until the step has closed, output stalls included.
// Throughput is set by the controller loop, which produces one output byte per cycle unless the output stalls.
// Reset: synchronous active-low rst_n empties the window and output, restores the registers.
`default_nettype none

module stream_find_replace #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  sfr_in_if.sink                              in_s,
  sfr_out_if.source                           out_s,
  input  wire logic                           cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Controller and datapath talk only through these two bundles.
  sfr_pkg::cmd_t cmd;
  sfr_pkg::sts_t sts;

  // Controller: accept a word, then walk the window check, replacement and flush, one emitted
  // byte per cycle unless the output stalls; steps close with the held byte, if any, or a marker at text end.
  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_s.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: hold the pending window and configuration, compare the window to the
  // pattern in parallel, and drive the registered output word.
  sfr_dpath #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_text_byte     (in_s.text_byte),
    .in_final_byte    (in_s.final_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (out_s.ready),
    .out_valid        (out_s.valid),
    .out_byte         (out_s.out_byte),
    .out_byte_present (out_s.byte_present),
    .out_run_last     (out_s.run_last),
    .out_text_end     (out_s.text_end)
  );

endmodule

`default_nettype wire

FILE: rtl/core/sfr_checker.sv
// Port-level checks for the stream find-and-replace block, bound to its top level.
`default_nettype none

module sfr_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [sfr_pkg::BYTE_W-1:0] out_byte,
  input wire logic                       byte_present,
  input wire logic                       run_last,
  input wire logic                       text_end
);

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_present)
      && $stable(run_last) && $stable(text_end))
    else $error("output word changed while stalled");

  // A bare end marker always closes both the step and the text.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_present |-> run_last && text_end)
    else $error("bare marker without end flags");

  // The end of the text is also the end of its step.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && text_end |-> run_last)
    else $error("text end on a non-final word of the step");

  // One byte is worked on at a time: no accept right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // Drop any output word on reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_s.valid),
  .in_ready     (in_s.ready),
  .out_valid    (out_s.valid),
  .out_ready    (out_s.ready),
  .out_byte     (out_s.out_byte),
  .byte_present (out_s.byte_present),
  .run_last     (out_s.run_last),
  .text_end     (out_s.text_end)
);

`default_nettype wire

FILE: verif/sfr_rewrite_checker.sv
`timescale 1ns / 100ps
// Scoreboard for stream_find_replace: mirrors the rewrite and checks every output word.
module sfr_rewrite_checker import sfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sfr_in_if                     in_w,
  sfr_out_if                    out_w,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    words_owed
);

  localparam int PATTERN_MAX = PATTERN_MAX_DEF;
  localparam int REPLACE_MAX = REPLACE_MAX_DEF;
  localparam int REPORT_MAX  = 60;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_present;
    logic              run_last;
    logic              text_end;
  } text_word_t;

  logic [LEN_W-1:0]      pat_len_q;
  logic [CFG_DATA_W-1:0] pat_bytes_q;
  logic [LEN_W-1:0]      rep_len_q;
  logic [CFG_DATA_W-1:0] rep_bytes_q;
  logic [BYTE_W-1:0]     window_q [PATTERN_MAX];
  int unsigned           window_fill;
  text_word_t            owed_words [$];
  int                    errors;

  initial errors = 0;

  // Rewrite one text byte and queue the output words it is owed.
  function automatic void rewrite_text_byte(input logic [BYTE_W-1:0] b, input logic ends_text);
    logic [BYTE_W-1:0] emitted [$];
    int unsigned       match_len, repl_len, i;
    bit                prefix_ok;
    text_word_t        w;
    match_len = (pat_len_q == 0) ? 1 : ((pat_len_q > PATTERN_MAX) ? PATTERN_MAX : pat_len_q);
    repl_len  = (rep_len_q > REPLACE_MAX) ? REPLACE_MAX : rep_len_q;
    if (window_fill >= PATTERN_MAX) window_fill = PATTERN_MAX - 1;
    window_q[window_fill] = b;
    window_fill++;
    // shed the oldest byte until the window could still start a match
    while (1) begin
      prefix_ok = (window_fill <= match_len);
      for (i = 0; prefix_ok && i < window_fill; i++)
        if (window_q[i] != pat_bytes_q[BYTE_W*i +: BYTE_W]) prefix_ok = 1'b0;
      if (prefix_ok) break;
      emitted.push_back(window_q[0]);
      for (i = 0; i + 1 < window_fill; i++) window_q[i] = window_q[i+1];
      window_fill--;
    end
    if (window_fill == match_len) begin
      for (i = 0; i < repl_len; i++) emitted.push_back(rep_bytes_q[BYTE_W*i +: BYTE_W]);
      window_fill = 0;
    end
    if (ends_text) begin
      for (i = 0; i < window_fill; i++) emitted.push_back(window_q[i]);
      window_fill = 0;
    end
    if (ends_text && emitted.size() == 0) begin
      w = '{out_byte: '0, byte_present: 1'b0, run_last: 1'b1, text_end: 1'b1};
      owed_words.push_back(w);
    end else begin
      for (i = 0; i < emitted.size(); i++) begin
        w.out_byte     = emitted[i];
        w.byte_present = 1'b1;
        w.run_last     = (i + 1 == emitted.size());
        w.text_end     = w.run_last && ends_text;
        owed_words.push_back(w);
      end
    end
  endfunction

  function automatic int field_differs(input string name, input logic [BYTE_W-1:0] want,
                                       input logic [BYTE_W-1:0] got);
    if (got === want) return 0;
    if (errors < REPORT_MAX)
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    text_word_t seen, want;
    if (!rst_n) begin
      pat_len_q   = LEN_W'(1);
      pat_bytes_q = '0;
      rep_len_q   = '0;
      rep_bytes_q = '0;
      window_fill = 0;
      owed_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PAT_LEN:   pat_len_q   = cfg_data[LEN_W-1:0];
          CFG_PAT_BYTES: pat_bytes_q = cfg_data;
          CFG_REP_LEN:   rep_len_q   = cfg_data[LEN_W-1:0];
          CFG_REP_BYTES: rep_bytes_q = cfg_data;
          default: ;
        endcase
      end
      if (out_w.valid && out_w.ready) begin
        seen = '{out_w.out_byte, out_w.byte_present, out_w.run_last, out_w.text_end};
        if (owed_words.size() == 0) begin
          if (errors < REPORT_MAX)
            $display("%0t ns: stray word: expected none, actual byte 0x%0h flags %b%b%b",
                     $time, seen.out_byte, seen.byte_present, seen.run_last, seen.text_end);
          errors++;
        end else begin
          want = owed_words.pop_front();
          errors += field_differs("out_byte", want.out_byte, seen.out_byte);
          errors += field_differs("byte_present", want.byte_present, seen.byte_present);
          errors += field_differs("run_last", want.run_last, seen.run_last);
          errors += field_differs("text_end", want.text_end, seen.text_end);
        end
      end
      if (in_w.valid && in_w.ready) rewrite_text_byte(in_w.text_byte, in_w.final_byte);
    end
    mismatch_count <= errors;
    words_owed     <= owed_words.size();
  end

endmodule

FILE: verif/tb_stream_find_replace.sv
`timescale 1ns / 100ps
// Testbench top for stream_find_replace: clock, reset, stimulus, output stalls and verdict.
module tb_stream_find_replace;
  import sfr_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    words_owed;

  // Shared with the output stall process: idling on/off and a requested long hold-off.
  bit idle_mode;
  int hold_off_cycles;

  sfr_in_if  text_ch ();
  sfr_out_if word_ch ();

  stream_find_replace u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (text_ch),
    .out_s     (word_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sfr_rewrite_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_w           (text_ch),
    .out_w          (word_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .words_owed     (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, even with every stall at its longest.
  initial begin
    #12_000_000;
    $display("tb_stream_find_replace: FAIL");
    $finish;
  end

  // Output side: stall in random bursts while idling is on, and honor a long hold-off
  // request so the block backs up and stalls its input.
  initial begin : word_sink
    int n;
    word_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      n = 0;
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
      end else if (idle_mode && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
      end
      if (n > 0) begin
        word_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        word_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one text word and hold it until taken. Keep valid high for the next word
  // unless this one closes a burst or a random gap follows.
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic ends_text,
                           input bit stop_after);
    int gap;
    text_ch.valid      <= 1'b1;
    text_ch.text_byte  <= b;
    text_ch.final_byte <= ends_text;
    do @(posedge clk); while (!text_ch.ready);
    gap = (idle_mode && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
    if (stop_after || gap > 0) text_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic reg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write all four registers back to back; junk fills the unused bits of the length words.
  task automatic set_config(input logic [LEN_W-1:0] plen, input logic [CFG_DATA_W-1:0] pbytes,
                            input logic [LEN_W-1:0] rlen, input logic [CFG_DATA_W-1:0] rbytes,
                            input bit junk);
    logic [CFG_DATA_W-1:0] pad;
    pad = junk ? {$urandom, $urandom} : '0;
    reg_write(CFG_PAT_LEN, {pad[CFG_DATA_W-1:LEN_W], plen});
    reg_write(CFG_PAT_BYTES, pbytes);
    reg_write(CFG_REP_LEN, {pad[CFG_DATA_W-1:LEN_W+1], ~pad[LEN_W], rlen});
    reg_write(CFG_REP_BYTES, rbytes);
    cfg_we <= 1'b0;
  endtask

  // Wait until every owed word has come out, then give a word that yields nothing
  // time to clear the block.
  task automatic wait_drained();
    do @(posedge clk); while (words_owed != 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0]     text_q [$];
    logic [BYTE_W-1:0]     alpha [2];
    logic [CFG_DATA_W-1:0] pat, rep;
    logic [LEN_W-1:0]      plen, rlen;
    int unsigned           eff_len, phase, phase_words, text_len, cut, i, k;
    bit                    open_text;

    rst_n              <= 1'b0;
    text_ch.valid      <= 1'b0;
    text_ch.text_byte  <= '0;
    text_ch.final_byte <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_PAT_LEN;
    cfg_data           <= '0;
    idle_mode       = 1'b1;
    hold_off_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset config: pattern is one NUL, replacement empty, so NULs vanish.
    // The closing NUL leaves nothing to emit: expect a bare end marker.
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    wait_drained();

    // "ab" -> "XYZ": a false start, a match, a flushed tail; then a match on the last byte.
    set_config(4'd2, 64'h6261, 4'd3, 64'h5A5958, 1'b0);
    send_word(8'h61, 1'b0, 1'b0);
    send_word(8'h61, 1'b0, 1'b0);
    send_word(8'h62, 1'b0, 1'b0);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h61, 1'b0, 1'b0);
    send_word(8'h62, 1'b1, 1'b1);
    wait_drained();

    // Zero pattern length acts as one; replacement length above the max saturates.
    set_config(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    wait_drained();

    // Pattern length above the max saturates to a full eight-byte pattern.
    set_config(4'd15, 64'h00FF_00FF_00FF_00FF, 4'd8, 64'h8040_2010_0804_0201, 1'b0);
    for (i = 0; i < 8; i++) send_word((i % 2 == 0) ? 8'hFF : 8'h00, i == 7, i == 7);
    wait_drained();

    // Change the pattern while "wxy" sits in the window; the next byte re-checks it.
    set_config(4'd4, 64'h7A79_7877, 4'd1, 64'h21, 1'b0);
    send_word(8'h77, 1'b0, 1'b0);
    send_word(8'h78, 1'b0, 1'b0);
    send_word(8'h79, 1'b0, 1'b1);
    wait_drained();
    set_config(4'd2, 64'h7978, 4'd2, 64'h2B2B, 1'b0);
    send_word(8'h71, 1'b1, 1'b1);

    // Random phases: each picks a config, then sends texts built mostly from planted
    // patterns and prefixes over a two-byte alphabet, with some fully random noise.
    for (phase = 0; phase < 12; phase++) begin
      wait_drained();
      idle_mode = !(phase == 5 || phase >= 10);
      alpha[0] = BYTE_W'($urandom_range(0, 255));
      alpha[1] = BYTE_W'($urandom_range(0, 255));
      for (i = 0; i < 8; i++)
        pat[BYTE_W*i +: BYTE_W] = ($urandom_range(0, 3) == 0) ?
                                  BYTE_W'($urandom_range(0, 255)) :
                                  alpha[$urandom_range(0, 1)];
      rep = {$urandom, $urandom};
      case (phase)
        0: begin plen = 4'd1;  rlen = 4'd0;  end
        1: begin plen = 4'd8;  rlen = 4'd8;  end
        2: begin plen = 4'd0;  rlen = 4'd15; end
        3: begin plen = 4'd15; rlen = 4'd1;  end
        default: begin
          plen = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 15))
                                             : LEN_W'($urandom_range(1, 4));
          rlen = LEN_W'($urandom_range(0, 9));
        end
      endcase
      set_config(plen, pat, rlen, rep, 1'b1);
      eff_len = (plen == 0) ? 1 : ((plen > 8) ? 8 : plen);
      // Starve the output for a long stretch while words keep coming.
      if (phase == 6) hold_off_cycles = 250;
      phase_words = 0;
      while (phase_words < 25) begin
        text_q.delete();
        text_len = $urandom_range(1, 12);
        while (text_q.size() < text_len) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3:
              for (i = 0; i < eff_len; i++) text_q.push_back(pat[BYTE_W*i +: BYTE_W]);
            4, 5: begin
              cut = $urandom_range(1, eff_len);
              for (i = 0; i < cut; i++) text_q.push_back(pat[BYTE_W*i +: BYTE_W]);
            end
            6, 7, 8: text_q.push_back(alpha[$urandom_range(0, 1)]);
            default: text_q.push_back(BYTE_W'($urandom_range(0, 255)));
          endcase
        end
        phase_words += text_q.size();
        // Sometimes leave the last text open so the next config lands mid-text.
        open_text = (phase_words >= 25) && (phase < 11) && ($urandom_range(0, 3) == 0);
        for (k = 0; k < text_q.size(); k++)
          send_word(text_q[k], (k + 1 == text_q.size()) && !open_text, k + 1 == text_q.size());
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb_stream_find_replace: PASS");
    end else begin
      $display("tb_stream_find_replace: FAIL");
    end
    $finish;
  end

endmodule
